// ----- sv/sstau_pkg.sv -----
package sstau_pkg;

    // Stall state bit positions within the six-bit state mask
    localparam int ST_IO_SOME  = 0;
    localparam int ST_IO_FULL  = 1;
    localparam int ST_MEM_SOME = 2;
    localparam int ST_MEM_FULL = 3;
    localparam int ST_CPU_SOME = 4;
    localparam int ST_NONIDLE  = 5;
    localparam int NUM_STATES  = 6;

    // Count positions within the per-cpu count triple and the masks
    localparam int CNT_IOWAIT   = 0;
    localparam int CNT_MEMSTALL = 1;
    localparam int CNT_RUNNING  = 2;
    localparam int NUM_COUNTS   = 3;

    localparam int TIME_W  = 64;
    localparam int ACC_W   = 32;
    localparam int CPU_IDX_W = 3;
    localparam int Q_DEPTH = 2;

    // Item opcodes
    localparam logic OP_TASK = 1'b0;

    // Configuration register indexes
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_TICK   = 1'b1;

    localparam logic [ACC_W-1:0] TICK_RESET = 32'd10000000;

    // What the back end has to do with an item
    typedef enum logic [1:0] {
        CLS_UPDATE,
        CLS_TICK,
        CLS_REPORT,
        CLS_NULL
    } item_cls_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        item_cls_t                cls;
        logic [CPU_IDX_W-1:0]     cpu;
        logic [NUM_COUNTS-1:0]    clr;
        logic [NUM_COUNTS-1:0]    set;
        logic [TIME_W-1:0]        now;
    } item_t;

    typedef struct packed {
        logic [NUM_STATES-1:0]             mask;
        logic [TIME_W-1:0]                 last;
        logic [NUM_STATES-1:0][ACC_W-1:0]  acc;
    } entry_t;

    typedef struct packed {
        logic              enable;
        logic [ACC_W-1:0]  tick_len;
    } cfg_t;

endpackage

// ----- sv/stall_state_time_accounting_unit.sv -----
// An accepted item moves from the input queue to the item register, and its result
// to the output register while no result waits. The back end takes a new item only
// once done with the last, as each item reads and writes back its per-cpu entry.
// The input queue holds two items and the output register one result.
// Reset (rst_n, asynchronous, active low) empties both queues, clears all
// entry valid bits so every cpu reads as zero, and restores the registers.
module stall_state_time_accounting_unit #(
    parameter int NUM_CPUS   = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic         opcode,
    input  logic [2:0]   cpu_index,
    input  logic [2:0]   clear_mask,
    input  logic [2:0]   set_mask,
    input  logic         task_memstalled,
    input  logic [63:0]  now_ns,
    output logic         empty,
    input  logic         pop,
    output logic [5:0]   active_mask,
    output logic [31:0]  io_some_time,
    output logic [31:0]  io_full_time,
    output logic [31:0]  mem_some_time,
    output logic [31:0]  mem_full_time,
    output logic [31:0]  cpu_some_time,
    output logic [31:0]  nonidle_time,
    output logic         count_underflow,
    input  logic         wr_en,
    input  logic         wr_index,
    input  logic [31:0]  wr_data
);

    logic                enable_reg;
    logic [31:0]         tick_len_reg;
    sstau_pkg::cfg_t     cfg;
    logic                q_pop;
    logic                q_empty;
    sstau_pkg::item_t    q_item;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            tick_len_reg <= sstau_pkg::TICK_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                sstau_pkg::REG_ENABLE: enable_reg   <= wr_data[0];
                sstau_pkg::REG_TICK:   tick_len_reg <= wr_data;
                default:               enable_reg   <= enable_reg;
            endcase
        end
    end

    assign cfg.enable   = enable_reg;
    assign cfg.tick_len = tick_len_reg;

    sstau_front #(
        .NUM_CPUS (NUM_CPUS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .opcode          (opcode),
        .cpu_index       (cpu_index),
        .clear_mask      (clear_mask),
        .set_mask        (set_mask),
        .task_memstalled (task_memstalled),
        .now_ns          (now_ns),
        .enable          (enable_reg),
        .q_pop           (q_pop),
        .q_empty         (q_empty),
        .q_item          (q_item)
    );

    sstau_back #(
        .NUM_CPUS   (NUM_CPUS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_empty         (q_empty),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .active_mask     (active_mask),
        .io_some_time    (io_some_time),
        .io_full_time    (io_full_time),
        .mem_some_time   (mem_some_time),
        .mem_full_time   (mem_full_time),
        .cpu_some_time   (cpu_some_time),
        .nonidle_time    (nonidle_time),
        .count_underflow (count_underflow)
    );

endmodule

// ----- sv/sstau_front.sv -----
module sstau_front #(
    parameter int NUM_CPUS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     opcode,
    input  logic [2:0]               cpu_index,
    input  logic [2:0]               clear_mask,
    input  logic [2:0]               set_mask,
    input  logic                     task_memstalled,
    input  logic [63:0]              now_ns,
    input  logic                     enable,
    input  logic                     q_pop,
    output logic                     q_empty,
    output sstau_pkg::item_t         q_item
);

    localparam int PTR_W = $clog2(sstau_pkg::Q_DEPTH);

    sstau_pkg::item_t    q_mem [sstau_pkg::Q_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [PTR_W:0]      count_reg;
    logic [PTR_W:0]      count_next;
    logic                accept;
    logic                in_range;
    sstau_pkg::item_t    new_item;

    // Classify the incoming item
    always_comb
    begin
        in_range      = {29'd0, cpu_index} < 32'(NUM_CPUS);
        new_item.cpu  = cpu_index;
        new_item.clr  = clear_mask;
        new_item.set  = set_mask;
        new_item.now  = now_ns;
        if (!in_range)
            new_item.cls = sstau_pkg::CLS_NULL;
        else if (!enable)
            new_item.cls = sstau_pkg::CLS_REPORT;
        else if (opcode == sstau_pkg::OP_TASK)
            new_item.cls = sstau_pkg::CLS_UPDATE;
        else if (task_memstalled)
            new_item.cls = sstau_pkg::CLS_TICK;
        else
            new_item.cls = sstau_pkg::CLS_REPORT;
    end

    assign full    = (count_reg == (PTR_W+1)'(sstau_pkg::Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign accept  = push && !full;
    assign q_item  = q_mem[rd_ptr_reg];

    // Advance the queue pointers
    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(accept) - (PTR_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (accept)
            q_mem[wr_ptr_reg] <= new_item;
    end

endmodule

// ----- sv/sstau_back.sv -----
module sstau_back #(
    parameter int NUM_CPUS   = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sstau_pkg::cfg_t      cfg,
    input  logic                 q_empty,
    input  sstau_pkg::item_t     q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [5:0]           active_mask,
    output logic [31:0]          io_some_time,
    output logic [31:0]          io_full_time,
    output logic [31:0]          mem_some_time,
    output logic [31:0]          mem_full_time,
    output logic [31:0]          cpu_some_time,
    output logic [31:0]          nonidle_time,
    output logic                 count_underflow
);

    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int NC    = sstau_pkg::NUM_COUNTS;
    localparam int NS    = sstau_pkg::NUM_STATES;
    localparam int AW    = sstau_pkg::ACC_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [NC-1:0][COUNT_BITS-1:0] cnt_set_t;

    // Per-cpu entry store with valid bits standing in for a reset clear
    sstau_pkg::entry_t       ent_mem [NUM_CPUS];
    cnt_set_t                cnt_mem [NUM_CPUS];
    logic [NUM_CPUS-1:0]     valid_reg;

    sstau_pkg::back_state_t  state_reg;
    sstau_pkg::back_state_t  state_next;
    sstau_pkg::item_t        item_reg;
    sstau_pkg::entry_t       rd_ent_reg;
    cnt_set_t                rd_cnt_reg;
    logic                    rd_valid_reg;

    logic                    issue;
    logic                    advance;
    logic                    charge;
    logic                    mem_wr;
    logic [CPU_W-1:0]        rd_idx;
    logic [CPU_W-1:0]        wr_idx;
    logic [31:0]             rd_cpu_ext;
    logic [31:0]             wr_cpu_ext;

    sstau_pkg::entry_t       cur_ent;
    cnt_set_t                cur_cnt;
    sstau_pkg::entry_t       ent_new;
    cnt_set_t                cnt_new;
    cnt_set_t                cnt_upd;
    logic [NS-1:0]           mask_upd;
    logic [AW-1:0]           delta;
    logic [AW-1:0]           tick_credit;
    logic                    under;

    sstau_pkg::entry_t       res_ent;
    logic                    res_under;
    logic                    out_valid_reg;

    assign rd_cpu_ext = {29'd0, q_item.cpu};
    assign wr_cpu_ext = {29'd0, item_reg.cpu};
    assign rd_idx     = rd_cpu_ext[CPU_W-1:0];
    assign wr_idx     = wr_cpu_ext[CPU_W-1:0];

    // Sequence: read the entry, then update it and post the result
    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        advance    = 1'b0;
        unique case (state_reg)
            sstau_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    issue      = 1'b1;
                    state_next = sstau_pkg::BK_EXEC;
                end
            end
            sstau_pkg::BK_EXEC:
            begin
                if (!out_valid_reg || pop)
                begin
                    advance    = 1'b1;
                    state_next = sstau_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sstau_pkg::BK_IDLE;
            end
        endcase
    end

    assign q_pop = issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sstau_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Latch the item and read its cpu entry
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            item_reg     <= q_item;
            rd_ent_reg   <= ent_mem[rd_idx];
            rd_cnt_reg   <= cnt_mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
        end
        if (mem_wr)
        begin
            ent_mem[wr_idx] <= ent_new;
            cnt_mem[wr_idx] <= cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (mem_wr)
            valid_reg[wr_idx] <= 1'b1;
    end

    assign cur_ent = rd_valid_reg ? rd_ent_reg : '0;
    assign cur_cnt = rd_valid_reg ? rd_cnt_reg : '0;
    assign charge  = (item_reg.cls == sstau_pkg::CLS_UPDATE) ||
                     (item_reg.cls == sstau_pkg::CLS_TICK);
    assign mem_wr  = advance && charge;

    // Charge elapsed time to active states; a tick may credit memory full
    always_comb
    begin
        logic [NS-1:0] m;
        m           = cur_ent.mask;
        delta       = item_reg.now[AW-1:0] - cur_ent.last[AW-1:0];
        tick_credit = (delta < cfg.tick_len) ? delta : cfg.tick_len;
        ent_new     = cur_ent;
        ent_new.last = item_reg.now;
        if (m[sstau_pkg::ST_IO_SOME])
        begin
            ent_new.acc[sstau_pkg::ST_IO_SOME] = cur_ent.acc[sstau_pkg::ST_IO_SOME] + delta;
            if (m[sstau_pkg::ST_IO_FULL])
                ent_new.acc[sstau_pkg::ST_IO_FULL] =
                    cur_ent.acc[sstau_pkg::ST_IO_FULL] + delta;
        end
        if (m[sstau_pkg::ST_MEM_SOME])
        begin
            ent_new.acc[sstau_pkg::ST_MEM_SOME] =
                cur_ent.acc[sstau_pkg::ST_MEM_SOME] + delta;
            if (m[sstau_pkg::ST_MEM_FULL])
                ent_new.acc[sstau_pkg::ST_MEM_FULL] =
                    cur_ent.acc[sstau_pkg::ST_MEM_FULL] + delta;
            else if (item_reg.cls == sstau_pkg::CLS_TICK)
                ent_new.acc[sstau_pkg::ST_MEM_FULL] =
                    cur_ent.acc[sstau_pkg::ST_MEM_FULL] + tick_credit;
        end
        if (m[sstau_pkg::ST_CPU_SOME])
            ent_new.acc[sstau_pkg::ST_CPU_SOME] =
                cur_ent.acc[sstau_pkg::ST_CPU_SOME] + delta;
        if (m[sstau_pkg::ST_NONIDLE])
            ent_new.acc[sstau_pkg::ST_NONIDLE] =
                cur_ent.acc[sstau_pkg::ST_NONIDLE] + delta;
        if (item_reg.cls == sstau_pkg::CLS_UPDATE)
            ent_new.mask = mask_upd;
    end

    // Move the counts; a clear of a zero count skips that count entirely
    always_comb
    begin
        cnt_upd = cur_cnt;
        under   = 1'b0;
        for (int t = 0; t < NC; t++)
        begin
            if (item_reg.clr[t])
            begin
                if (cur_cnt[t] == '0)
                    under = 1'b1;
                else if (!item_reg.set[t])
                    cnt_upd[t] = cur_cnt[t] - 1'b1;
            end
            else if (item_reg.set[t] && (cur_cnt[t] != CNT_MAX))
            begin
                cnt_upd[t] = cur_cnt[t] + 1'b1;
            end
        end
        cnt_new = (item_reg.cls == sstau_pkg::CLS_UPDATE) ? cnt_upd : cur_cnt;
    end

    // Derive the state mask from the new counts
    always_comb
    begin
        logic io;
        logic mem;
        logic run;
        io  = |cnt_upd[sstau_pkg::CNT_IOWAIT];
        mem = |cnt_upd[sstau_pkg::CNT_MEMSTALL];
        run = |cnt_upd[sstau_pkg::CNT_RUNNING];
        mask_upd = '0;
        mask_upd[sstau_pkg::ST_IO_SOME]  = io;
        mask_upd[sstau_pkg::ST_IO_FULL]  = io && !run;
        mask_upd[sstau_pkg::ST_MEM_SOME] = mem;
        mask_upd[sstau_pkg::ST_MEM_FULL] = mem && !run;
        mask_upd[sstau_pkg::ST_CPU_SOME] =
            cnt_upd[sstau_pkg::CNT_RUNNING] > COUNT_BITS'(1);
        mask_upd[sstau_pkg::ST_NONIDLE]  = io || mem || run;
    end

    // Pick the reported values
    always_comb
    begin
        case (item_reg.cls)
            sstau_pkg::CLS_NULL:
            begin
                res_ent   = '0;
                res_under = 1'b0;
            end
            sstau_pkg::CLS_REPORT:
            begin
                res_ent   = cur_ent;
                res_under = 1'b0;
            end
            sstau_pkg::CLS_TICK:
            begin
                res_ent   = ent_new;
                res_under = 1'b0;
            end
            default:
            begin
                res_ent   = ent_new;
                res_under = under;
            end
        endcase
    end

    // Hold the result until it is popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            active_mask     <= res_ent.mask;
            io_some_time    <= res_ent.acc[sstau_pkg::ST_IO_SOME];
            io_full_time    <= res_ent.acc[sstau_pkg::ST_IO_FULL];
            mem_some_time   <= res_ent.acc[sstau_pkg::ST_MEM_SOME];
            mem_full_time   <= res_ent.acc[sstau_pkg::ST_MEM_FULL];
            cpu_some_time   <= res_ent.acc[sstau_pkg::ST_CPU_SOME];
            nonidle_time    <= res_ent.acc[sstau_pkg::ST_NONIDLE];
            count_underflow <= res_under;
        end
    end

    assign empty = !out_valid_reg;

    // A waiting result blocks the back end
    a_hold_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sstau_pkg::BK_EXEC && out_valid_reg && !pop)
        |=> (state_reg == sstau_pkg::BK_EXEC))
        else $error("back end advanced over a waiting result");

    // The queue is drained only from idle and never when empty
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == sstau_pkg::BK_IDLE && !q_empty))
        else $error("queue popped out of turn");

    // Only task changes can flag an underflow
    a_under_task: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.cls != sstau_pkg::CLS_UPDATE) |=> !count_underflow)
        else $error("underflow flagged on a non-update item");

    // Out-of-range cpus report nothing
    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.cls == sstau_pkg::CLS_NULL)
        |=> (active_mask == '0 && nonidle_time == '0))
        else $error("out-of-range cpu reported values");

    // An io full state never shows without its io some state
    a_full_nests: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(active_mask[sstau_pkg::ST_IO_FULL] &&
                            !active_mask[sstau_pkg::ST_IO_SOME]))
        else $error("io full state without io some");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD    = 12;
    localparam int LIMIT_CYCLES  = 1_200_000;
    localparam int NUM_CPUS      = 8;
    localparam int COUNT_BITS    = 8;
    localparam int SAT_CPU       = 5;
    localparam int PHASE_ITEMS   = 140;
    localparam int MAX_PRINTED   = 100;
    localparam int CPU_W         = sstau_pkg::CPU_IDX_W;
    localparam int NC            = sstau_pkg::NUM_COUNTS;
    localparam int NS            = sstau_pkg::NUM_STATES;
    localparam int AW            = sstau_pkg::ACC_W;
    localparam int TW            = sstau_pkg::TIME_W;
    localparam logic OP_TICK     = ~sstau_pkg::OP_TASK;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic              opcode;
        logic [CPU_W-1:0]  cpu;
        logic [NC-1:0]     clr_bits;
        logic [NC-1:0]     set_bits;
        logic              memst;
        logic [TW-1:0]     now;
    } sched_event_t;

    typedef struct packed {
        logic [NS-1:0]           mask;
        logic [NS-1:0][AW-1:0]   times;
        logic                    under;
    } stall_report_t;

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               push     = 1'b0;
    logic               pop      = 1'b0;
    logic               wr_en    = 1'b0;
    logic               wr_index = sstau_pkg::REG_ENABLE;
    logic [AW-1:0]      wr_data  = '0;
    sched_event_t       in_item  = '0;
    logic               full;
    logic               empty;
    logic [5:0]         active_mask;
    logic [31:0]        io_some_time;
    logic [31:0]        io_full_time;
    logic [31:0]        mem_some_time;
    logic [31:0]        mem_full_time;
    logic [31:0]        cpu_some_time;
    logic [31:0]        nonidle_time;
    logic               count_underflow;

    wire [NS-1:0][AW-1:0] seen_times = {nonidle_time, cpu_some_time,
        mem_full_time, mem_some_time, io_full_time, io_some_time};

    string time_names [NS] = '{"io_some_time", "io_full_time", "mem_some_time",
        "mem_full_time", "cpu_some_time", "nonidle_time"};

    // Predicted copy of the accounting state and the registers
    logic                   acct_enable;
    logic [AW-1:0]          tick_ns;
    logic [COUNT_BITS-1:0]  task_counts [NUM_CPUS][NC];
    logic [NS-1:0]          cpu_states [NUM_CPUS];
    logic [TW-1:0]          cpu_last_ns [NUM_CPUS];
    logic [NS-1:0][AW-1:0]  cpu_stall_ns [NUM_CPUS];

    stall_report_t awaited_reports [$];
    int            mismatch_count   = 0;
    int            results_hold_req = 0;
    int            gap_run_left     = 0;
    bit            sender_idling    = 1'b0;
    bit            receiver_idling  = 1'b0;

    stall_state_time_accounting_unit #(
        .NUM_CPUS   (NUM_CPUS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .opcode          (in_item.opcode),
        .cpu_index       (in_item.cpu),
        .clear_mask      (in_item.clr_bits),
        .set_mask        (in_item.set_bits),
        .task_memstalled (in_item.memst),
        .now_ns          (in_item.now),
        .empty           (empty),
        .pop             (pop),
        .active_mask     (active_mask),
        .io_some_time    (io_some_time),
        .io_full_time    (io_full_time),
        .mem_some_time   (mem_some_time),
        .mem_full_time   (mem_full_time),
        .cpu_some_time   (cpu_some_time),
        .nonidle_time    (nonidle_time),
        .count_underflow (count_underflow),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("testbench: done, errors");
        $finish;
    end

    task automatic flag_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
        // Keep the log short when something breaks badly
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, seen, wanted);
        mismatch_count++;
    endtask

    // Charge the wrapped delta to every active state; a tick may credit memory full
    function automatic void charge_stall(int c, logic [TW-1:0] now, bit tick);
        logic [AW-1:0] delta;
        logic [NS-1:0] m;
        delta = now[AW-1:0] - cpu_last_ns[c][AW-1:0];
        m = cpu_states[c];
        cpu_last_ns[c] = now;
        if (m[sstau_pkg::ST_IO_SOME])
        begin
            cpu_stall_ns[c][sstau_pkg::ST_IO_SOME] += delta;
            if (m[sstau_pkg::ST_IO_FULL])
                cpu_stall_ns[c][sstau_pkg::ST_IO_FULL] += delta;
        end
        if (m[sstau_pkg::ST_MEM_SOME])
        begin
            cpu_stall_ns[c][sstau_pkg::ST_MEM_SOME] += delta;
            if (m[sstau_pkg::ST_MEM_FULL])
                cpu_stall_ns[c][sstau_pkg::ST_MEM_FULL] += delta;
            else if (tick)
                cpu_stall_ns[c][sstau_pkg::ST_MEM_FULL] +=
                    (delta < tick_ns) ? delta : tick_ns;
        end
        if (m[sstau_pkg::ST_CPU_SOME])
            cpu_stall_ns[c][sstau_pkg::ST_CPU_SOME] += delta;
        if (m[sstau_pkg::ST_NONIDLE])
            cpu_stall_ns[c][sstau_pkg::ST_NONIDLE] += delta;
    endfunction

    // Apply one event to the predicted state and return the report it should give
    function automatic stall_report_t account_item(sched_event_t it);
        stall_report_t         rep;
        logic [COUNT_BITS-1:0] io_n;
        logic [COUNT_BITS-1:0] mem_n;
        logic [COUNT_BITS-1:0] run_n;
        int                    c;
        int                    t;
        c = int'(it.cpu);
        rep.under = 1'b0;
        if (acct_enable)
        begin
            if (it.opcode == sstau_pkg::OP_TASK)
            begin
                charge_stall(c, it.now, 1'b0);
                for (t = 0; t < NC; t++)
                begin
                    // A clear of a zero count skips the set of that count too
                    if (it.clr_bits[t] && task_counts[c][t] == '0)
                        rep.under = 1'b1;
                    else
                    begin
                        if (it.clr_bits[t])
                            task_counts[c][t] = task_counts[c][t] - 1'b1;
                        if (it.set_bits[t] && task_counts[c][t] != COUNT_MAX)
                            task_counts[c][t] = task_counts[c][t] + 1'b1;
                    end
                end
                io_n  = task_counts[c][sstau_pkg::CNT_IOWAIT];
                mem_n = task_counts[c][sstau_pkg::CNT_MEMSTALL];
                run_n = task_counts[c][sstau_pkg::CNT_RUNNING];
                cpu_states[c] = '0;
                cpu_states[c][sstau_pkg::ST_IO_SOME]  = (io_n != 0);
                cpu_states[c][sstau_pkg::ST_IO_FULL]  = (io_n != 0) && (run_n == 0);
                cpu_states[c][sstau_pkg::ST_MEM_SOME] = (mem_n != 0);
                cpu_states[c][sstau_pkg::ST_MEM_FULL] = (mem_n != 0) && (run_n == 0);
                cpu_states[c][sstau_pkg::ST_CPU_SOME] = (run_n > 1);
                cpu_states[c][sstau_pkg::ST_NONIDLE]  =
                    (io_n != 0) || (mem_n != 0) || (run_n != 0);
            end
            else if (it.memst)
                charge_stall(c, it.now, 1'b1);
        end
        rep.mask  = cpu_states[c];
        rep.times = cpu_stall_ns[c];
        return rep;
    endfunction

    function automatic sched_event_t build_item(logic op, int cpu, int clr, int set_bits,
                                                bit memst, logic [TW-1:0] now);
        sched_event_t it;
        it.opcode   = op;
        it.cpu      = CPU_W'(cpu);
        it.clr_bits = NC'(clr);
        it.set_bits = NC'(set_bits);
        it.memst    = memst;
        it.now      = now;
        return it;
    endfunction

    // Mostly legal count changes with moving timestamps, some noise mixed in
    function automatic sched_event_t draw_sched_event();
        sched_event_t  it;
        logic [NC-1:0] nonzero;
        int            c;
        int            t;
        c = $urandom_range(0, NUM_CPUS - 1);
        for (t = 0; t < NC; t++)
            nonzero[t] = (task_counts[c][t] != 0);
        it.cpu      = CPU_W'(c);
        it.opcode   = ($urandom_range(0, 3) == 0) ? OP_TICK : sstau_pkg::OP_TASK;
        it.memst    = 1'($urandom_range(0, 1));
        it.set_bits = NC'($urandom_range(0, 7));
        it.clr_bits = NC'($urandom_range(0, 7));
        if ($urandom_range(0, 9) != 0)
            it.clr_bits &= nonzero;
        case ($urandom_range(0, 19))
            0:       it.now = {$urandom, $urandom};
            1:       it.now = cpu_last_ns[c] - $urandom_range(0, 100000);
            2:       it.now = cpu_last_ns[c] + {32'd0, $urandom};
            default: it.now = cpu_last_ns[c] + $urandom_range(0, 50000000);
        endcase
        return it;
    endfunction

    // Offer one item, with random gaps in front when pacing is on
    task automatic send_item(sched_event_t it);
        int gap;
        if (sender_idling)
        begin
            if (gap_run_left > 0)
                gap_run_left--;
            else
            begin
                gap = $urandom_range(1, 15);
                gap_run_left = $urandom_range(0, 15);
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        push    <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (full);
        awaited_reports.push_back(account_item(it));
    endtask

    // Stop offering and hold until every awaited report has arrived
    task automatic await_results();
        @(negedge clk);
        push <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic index, logic [AW-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        if (index == sstau_pkg::REG_ENABLE)
            acct_enable = data[0];
        else
            tick_ns = data;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Drive pop in bursts; a hold request stalls it for a counted stretch
    initial
    begin : result_sink
        int hold_left;
        int burst_left;
        bit burst_pop;
        hold_left  = 0;
        burst_left = 0;
        burst_pop  = 1'b1;
        forever
        begin
            @(negedge clk);
            if (results_hold_req != 0)
            begin
                hold_left = results_hold_req;
                results_hold_req = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 15);
                    burst_pop  = !receiver_idling || ($urandom_range(0, 1) == 1);
                end
                burst_left--;
                pop <= burst_pop;
            end
        end
    end

    // Compare each accepted report with the oldest prediction
    always @(posedge clk)
    begin : report_check
        stall_report_t want;
        int            s;
        if (rst_n && pop && !empty)
        begin
            if (awaited_reports.size() == 0)
                flag_mismatch("report with none awaited", 64'(active_mask), 64'd0);
            else
            begin
                want = awaited_reports.pop_front();
                if (active_mask !== want.mask)
                    flag_mismatch("active_mask", 64'(active_mask), 64'(want.mask));
                for (s = 0; s < NS; s++)
                    if (seen_times[s] !== want.times[s])
                        flag_mismatch(time_names[s], 64'(seen_times[s]),
                                      64'(want.times[s]));
                if (count_underflow !== want.under)
                    flag_mismatch("count_underflow", 64'(count_underflow),
                                  64'(want.under));
            end
        end
    end

    task automatic test_directed_sequences();
        // Fresh cpu reads as zero
        send_item(build_item(OP_TICK, 3, 0, 0, 1'b0, 64'd0));
        // Nested full states with no running task
        send_item(build_item(sstau_pkg::OP_TASK, 0, 0, 7, 1'b0, 64'd100));
        send_item(build_item(sstau_pkg::OP_TASK, 0, 4, 0, 1'b0, 64'd1000));
        send_item(build_item(OP_TICK, 0, 0, 0, 1'b1, 64'd5000));
        send_item(build_item(OP_TICK, 0, 7, 7, 1'b0, 64'd9000));
        // Time going backwards
        send_item(build_item(sstau_pkg::OP_TASK, 0, 1, 1, 1'b0, 64'd3000));
        // Clear of zero counts on an idle cpu
        send_item(build_item(sstau_pkg::OP_TASK, 2, 7, 7, 1'b0, 64'd50));
        // Memory some with a runner: the tick credit is capped
        send_item(build_item(sstau_pkg::OP_TASK, 1, 0, 6, 1'b0, 64'd10));
        send_item(build_item(sstau_pkg::OP_TASK, 1, 0, 4, 1'b0, 64'd20));
        send_item(build_item(OP_TICK, 1, 0, 0, 1'b1, 64'h4000_0014));
        send_item(build_item(OP_TICK, 1, 0, 0, 1'b1, 64'h4000_0208));
        send_item(build_item(sstau_pkg::OP_TASK, 1, 4, 0, 1'b1, 64'h4000_1000));
        send_item(build_item(sstau_pkg::OP_TASK, 1, 2, 2, 1'b0, 64'h4000_2000));
        send_item(build_item(sstau_pkg::OP_TASK, 1, 1, 1, 1'b0, 64'h4000_3000));
        // Timestamp extremes and wrap
        send_item(build_item(sstau_pkg::OP_TASK, 7, 0, 7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(build_item(sstau_pkg::OP_TASK, 7, 7, 0, 1'b0, 64'd0));
        send_item(build_item(sstau_pkg::OP_TASK, 6, 0, 1, 1'b0, 64'h8000_0000_0000_0000));
        send_item(build_item(OP_TICK, 6, 7, 7, 1'b1, 64'h8000_0001_0000_0005));
        send_item(build_item(sstau_pkg::OP_TASK, 4, 2, 7, 1'b1, 64'h0000_0000_FFFF_FFFF));
        await_results();
    endtask

    task automatic test_register_settings();
        // Disabled: nothing moves and no underflow is flagged
        write_register(sstau_pkg::REG_ENABLE, 32'd0);
        send_item(build_item(sstau_pkg::OP_TASK, 0, 0, 7, 1'b0, 64'hDEAD_BEEF_0000_0000));
        send_item(build_item(OP_TICK, 1, 0, 0, 1'b1, 64'h7FFF_FFFF_FFFF));
        send_item(build_item(sstau_pkg::OP_TASK, 2, 7, 7, 1'b0, 64'd77));
        await_results();
        // Tick length extremes on a cpu in memory some without full
        write_register(sstau_pkg::REG_ENABLE, 32'd1);
        write_register(sstau_pkg::REG_TICK, 32'd1);
        send_item(build_item(OP_TICK, 1, 0, 0, 1'b1, cpu_last_ns[1] + 64'd1000));
        await_results();
        write_register(sstau_pkg::REG_TICK, 32'hFFFF_FFFF);
        send_item(build_item(OP_TICK, 1, 0, 0, 1'b1, cpu_last_ns[1] + 64'hFFFF_FFFF));
        await_results();
        write_register(sstau_pkg::REG_TICK, 32'd0);
        send_item(build_item(OP_TICK, 1, 0, 0, 1'b1, cpu_last_ns[1] + 64'd777));
        await_results();
        write_register(sstau_pkg::REG_TICK, sstau_pkg::TICK_RESET);
    endtask

    task automatic test_backpressure();
        // Hold results off while items keep coming, then let it all drain
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        results_hold_req = 150;
        repeat (24) send_item(draw_sched_event());
        await_results();
    endtask

    task automatic test_random_phases();
        int p;
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
        for (p = 0; p < 6; p++)
        begin
            case (p)
                0: write_register(sstau_pkg::REG_TICK, sstau_pkg::TICK_RESET);
                1: write_register(sstau_pkg::REG_TICK, 32'd1);
                2: write_register(sstau_pkg::REG_TICK, 32'hFFFF_FFFF);
                3: write_register(sstau_pkg::REG_TICK, $urandom);
                4: write_register(sstau_pkg::REG_TICK, $urandom_range(1, 20000000));
                default: write_register(sstau_pkg::REG_TICK, 32'd0);
            endcase
            write_register(sstau_pkg::REG_ENABLE, (p == 3) ? 32'd0 : 32'd1);
            repeat (PHASE_ITEMS) send_item(draw_sched_event());
            await_results();
        end
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
    endtask

    task automatic test_count_saturation();
        // Drive all three counts of one cpu to the top and past it
        write_register(sstau_pkg::REG_ENABLE, 32'd1);
        write_register(sstau_pkg::REG_TICK, sstau_pkg::TICK_RESET);
        while (task_counts[SAT_CPU][sstau_pkg::CNT_IOWAIT] != COUNT_MAX
               || task_counts[SAT_CPU][sstau_pkg::CNT_MEMSTALL] != COUNT_MAX
               || task_counts[SAT_CPU][sstau_pkg::CNT_RUNNING] != COUNT_MAX)
            send_item(build_item(sstau_pkg::OP_TASK, SAT_CPU, 0, 7, 1'b0,
                                 cpu_last_ns[SAT_CPU] + 64'd3));
        repeat (2) send_item(build_item(sstau_pkg::OP_TASK, SAT_CPU, 0, 7, 1'b0,
                                        cpu_last_ns[SAT_CPU] + 64'd5));
        send_item(build_item(sstau_pkg::OP_TASK, SAT_CPU, 7, 7, 1'b0,
                             cpu_last_ns[SAT_CPU] + 64'd9));
        send_item(build_item(sstau_pkg::OP_TASK, SAT_CPU, 7, 0, 1'b0,
                             cpu_last_ns[SAT_CPU] + 64'd9));
        await_results();
    endtask

    task automatic test_random_unpaced();
        repeat (200) send_item(draw_sched_event());
        await_results();
    endtask

    initial
    begin : run_tests
        int c;
        int t;
        acct_enable = 1'b1;
        tick_ns     = sstau_pkg::TICK_RESET;
        for (c = 0; c < NUM_CPUS; c++)
        begin
            for (t = 0; t < NC; t++)
                task_counts[c][t] = '0;
            cpu_states[c]   = '0;
            cpu_last_ns[c]  = '0;
            cpu_stall_ns[c] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_sequences();
        test_register_settings();
        test_backpressure();
        test_random_phases();
        test_count_saturation();
        test_random_unpaced();

        // Let any stray report show up before closing
        repeat (20) @(posedge clk);
        if (awaited_reports.size() != 0)
            flag_mismatch("reports never arrived", 64'd0, 64'(awaited_reports.size()));
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sstau_pkg.sv
sv/sstau_front.sv
sv/sstau_back.sv
sv/stall_state_time_accounting_unit.sv
tb/sv/testbench.sv
